FILE: sv/sobm_pkg.sv
// Shared types and constants for the Sobel edge magnitude core.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sobm_pkg;

    localparam int PIX_W          = 8;
    localparam int POS_W          = 11;
    localparam int CFG_W          = 12;
    localparam int CFG_IDX_W      = 1;
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Sum of squares at and above which the rounded root saturates.
    localparam int SUMSQ_W = 21;
    localparam logic [SUMSQ_W-1:0] SAT_LIMIT = 21'd65281;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    typedef struct packed {
        logic latch;
        logic upd;
        logic grad;
        logic square;
        logic sum;
        logic root;
        logic round;
        logic load_int;
        logic load_bdr;
    } t_cmd;

    typedef struct packed {
        logic is_int;
        logic is_bdr;
        logic root_last;
    } t_status;

endpackage

`default_nettype wire

FILE: sv/sobm_ram.sv
// Generic single-port RAM with registered read data.
// Used for the line stores; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module sobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_addr,
    input  wire  [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

FILE: sv/sobm_ctrl.sv
// Sequencing controller: handshakes, per-item step order and output valid.
// Depends on sobm_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module sobm_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output sobm_pkg::t_cmd    o_cmd,
    input  sobm_pkg::t_status i_status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_UPD,
        S_GRAD,
        S_SQR,
        S_SUM,
        S_ROOT,
        S_RND,
        S_OUT_INT,
        S_OUT_BDR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free  = !o_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = o_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                priority if (i_status.is_int) begin
                    n_state = S_GRAD;
                end else if (i_status.is_bdr) begin
                    n_state = S_OUT_BDR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_GRAD: begin
                o_cmd.grad = 1'b1;
                n_state    = S_SQR;
            end
            S_SQR: begin
                o_cmd.square = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root = 1'b1;
                if (i_status.root_last) begin
                    n_state = S_RND;
                end
            end
            S_RND: begin
                o_cmd.round = 1'b1;
                n_state     = S_OUT_INT;
            end
            S_OUT_INT: begin
                if (slot_free) begin
                    o_cmd.load_int = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = i_status.is_bdr ? S_OUT_BDR : S_IDLE;
                end
            end
            S_OUT_BDR: begin
                if (slot_free) begin
                    o_cmd.load_bdr = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            o_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

FILE: sv/sobm_dp.sv
// Datapath: geometry registers, position counters, line stores, 3x3 window,
// gradient, iterative square root and the output register.
// Depends on sobm_pkg and sobm_ram.
`timescale 1ns / 1ps
`default_nettype none

module sobm_dp #(
    parameter int MAX_WIDTH  = sobm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sobm_pkg::MAX_HEIGHT_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [sobm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [sobm_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire  [sobm_pkg::PIX_W-1:0]          i_luma,
    input  wire  [sobm_pkg::PIX_W-1:0]          i_alpha,
    input  sobm_pkg::t_cmd                      i_cmd,
    output sobm_pkg::t_status                   o_status,
    output logic [sobm_pkg::POS_W-1:0]          o_col,
    output logic [sobm_pkg::POS_W-1:0]          o_row,
    output logic [sobm_pkg::PIX_W-1:0]          o_magnitude,
    output logic [sobm_pkg::PIX_W-1:0]          o_alpha_out,
    output logic                                o_last
);

    localparam int PW    = sobm_pkg::PIX_W;
    localparam int POS_W = sobm_pkg::POS_W;
    localparam int CFG_W = sobm_pkg::CFG_W;
    localparam int SQW   = sobm_pkg::SUMSQ_W;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WDW   = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1);
    localparam int HDW   = (CFG_W > $clog2(MAX_HEIGHT + 1)) ? CFG_W : $clog2(MAX_HEIGHT + 1);
    localparam int GW    = PW + 2;
    localparam int G2W   = 2 * GW;

    logic [CFG_W-1:0] r_cfg_w;
    logic [CFG_W-1:0] r_cfg_h;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [CW-1:0]    r_c;
    logic [RW-1:0]    r_r;
    logic             r_is_int;
    logic             r_is_bdr;
    logic [PW-1:0]    r_luma;
    logic [PW-1:0]    r_alpha;
    logic [PW-1:0]    r_alpha_delay;
    logic [PW-1:0]    r_int_alpha;
    logic [PW-1:0]    r_win [3][3];
    logic [GW-1:0]    r_gx;
    logic [GW-1:0]    r_gy;
    logic [G2W-1:0]   r_gx2;
    logic [G2W-1:0]   r_gy2;
    logic [SQW-1:0]   r_n;
    logic [PW-1:0]    r_s;
    logic [2*PW-1:0]  r_s_sq;
    logic [PW-1:0]    r_bit;
    logic [PW-1:0]    r_mag;

    logic [WDW-1:0]   w_eff;
    logic [HDW-1:0]   h_eff;
    logic             wrap_in;
    logic [CW-1:0]    c;
    logic [RW:0]      row_t;
    logic [RW-1:0]    r;
    logic [WDW-1:0]   c1;
    logic [HDW-1:0]   r1;
    logic [CW-1:0]    n_col;
    logic [RW-1:0]    n_row;
    logic             is_int;
    logic             is_bdr;

    logic [PW-1:0]    prev_rd;
    logic [PW-1:0]    prev2_rd;
    logic [PW-1:0]    alpha_rd;

    logic [GW-1:0]    gx_pos;
    logic [GW-1:0]    gx_neg;
    logic [GW-1:0]    gy_pos;
    logic [GW-1:0]    gy_neg;
    logic [PW-1:0]    root_t;
    logic [2*PW-1:0]  root_tt;
    logic [SQW-1:0]   root_rem;

    always_comb begin
        priority if (r_cfg_w == '0) begin
            w_eff = WDW'(1);
        end else if (WDW'(r_cfg_w) > WDW'(MAX_WIDTH)) begin
            w_eff = WDW'(MAX_WIDTH);
        end else begin
            w_eff = WDW'(r_cfg_w);
        end
        priority if (r_cfg_h == '0) begin
            h_eff = HDW'(1);
        end else if (HDW'(r_cfg_h) > HDW'(MAX_HEIGHT)) begin
            h_eff = HDW'(MAX_HEIGHT);
        end else begin
            h_eff = HDW'(r_cfg_h);
        end
    end

    always_comb begin
        wrap_in = (WDW'(r_col) >= w_eff);
        c       = wrap_in ? '0 : r_col;
        row_t   = wrap_in ? ({1'b0, r_row} + (RW+1)'(1)) : {1'b0, r_row};
        r       = (HDW'(row_t) >= h_eff) ? '0 : row_t[RW-1:0];
        c1      = WDW'(c) + WDW'(1);
        r1      = HDW'(r) + HDW'(1);
        if (c1 >= w_eff) begin
            n_col = '0;
            n_row = (r1 >= h_eff) ? '0 : r1[RW-1:0];
        end else begin
            n_col = c1[CW-1:0];
            n_row = r;
        end
        is_int = (WDW'(c) >= WDW'(2)) && (HDW'(r) >= HDW'(2));
        is_bdr = (c == '0) || (WDW'(c) == w_eff - WDW'(1))
              || (r == '0) || (HDW'(r) == h_eff - HDW'(1));
    end

    sobm_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.upd),
        .i_addr  (r_c),
        .i_wdata (r_luma),
        .o_rdata (prev_rd)
    );

    sobm_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_prev2_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.upd),
        .i_addr  (r_c),
        .i_wdata (prev_rd),
        .o_rdata (prev2_rd)
    );

    sobm_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_alpha_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.upd),
        .i_addr  (r_c),
        .i_wdata (r_alpha),
        .o_rdata (alpha_rd)
    );

    always_comb begin
        gx_pos = GW'(r_win[0][2]) + (GW'(r_win[1][2]) << 1) + GW'(r_win[2][2]);
        gx_neg = GW'(r_win[0][0]) + (GW'(r_win[1][0]) << 1) + GW'(r_win[2][0]);
        gy_pos = GW'(r_win[2][0]) + (GW'(r_win[2][1]) << 1) + GW'(r_win[2][2]);
        gy_neg = GW'(r_win[0][0]) + (GW'(r_win[0][1]) << 1) + GW'(r_win[0][2]);
        root_t   = r_s | r_bit;
        root_tt  = (2*PW)'(root_t) * (2*PW)'(root_t);
        root_rem = r_n - SQW'(r_s_sq);
    end

    assign o_status.is_int    = r_is_int;
    assign o_status.is_bdr    = r_is_bdr;
    assign o_status.root_last = r_bit[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w       <= sobm_pkg::WIDTH_RESET;
            r_cfg_h       <= sobm_pkg::HEIGHT_RESET;
            r_col         <= '0;
            r_row         <= '0;
            r_alpha_delay <= '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sobm_pkg::REG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data;
                    sobm_pkg::REG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.latch) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_cmd.upd) begin
                for (int i = 0; i < 3; i++) begin
                    r_win[i][0] <= r_win[i][1];
                    r_win[i][1] <= r_win[i][2];
                end
                r_win[0][2]   <= prev2_rd;
                r_win[1][2]   <= prev_rd;
                r_win[2][2]   <= r_luma;
                r_alpha_delay <= alpha_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_c      <= c;
            r_r      <= r;
            r_is_int <= is_int;
            r_is_bdr <= is_bdr;
            r_luma   <= i_luma;
            r_alpha  <= i_alpha;
        end
        if (i_cmd.upd) begin
            r_int_alpha <= r_alpha_delay;
        end
        if (i_cmd.grad) begin
            r_gx <= (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
            r_gy <= (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
        end
        if (i_cmd.square) begin
            r_gx2 <= G2W'(r_gx) * G2W'(r_gx);
            r_gy2 <= G2W'(r_gy) * G2W'(r_gy);
        end
        if (i_cmd.sum) begin
            r_n    <= SQW'(r_gx2) + SQW'(r_gy2);
            r_s    <= '0;
            r_s_sq <= '0;
            r_bit  <= {1'b1, {(PW-1){1'b0}}};
        end
        if (i_cmd.root) begin
            if (SQW'(root_tt) <= r_n) begin
                r_s    <= root_t;
                r_s_sq <= root_tt;
            end
            r_bit <= r_bit >> 1;
        end
        if (i_cmd.round) begin
            priority if (r_n >= sobm_pkg::SAT_LIMIT) begin
                r_mag <= '1;
            end else if (root_rem > SQW'(r_s)) begin
                r_mag <= r_s + PW'(1);
            end else begin
                r_mag <= r_s;
            end
        end
        if (i_cmd.load_int) begin
            o_col       <= POS_W'(r_c - CW'(1));
            o_row       <= POS_W'(r_r - RW'(1));
            o_magnitude <= r_mag;
            o_alpha_out <= r_int_alpha;
            o_last      <= !r_is_bdr;
        end else if (i_cmd.load_bdr) begin
            o_col       <= POS_W'(r_c);
            o_row       <= POS_W'(r_r);
            o_magnitude <= '0;
            o_alpha_out <= r_alpha;
            o_last      <= 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: sv/sobel_edge_magnitude_core.sv
// Top level of the Sobel 3x3 gradient magnitude core.
// Depends on sobm_pkg, sobm_ctrl and sobm_dp (which holds the sobm_ram line stores).
//
// Pixels arrive in raster order, one item per luma/alpha pair, and each item yields zero,
// one or two results tagged with column and row: border pixels come out at once with
// magnitude 0, and an interior pixel comes out when its lower-right neighbor arrives,
// ahead of any border result of that same item, with tlast on the final result of the item.
// Items are handled one at a time: each is latched, read from the line stores and written
// back; one that completes an interior pixel then runs the gradient, square, sum, square
// root and rounding steps, and each result waits in its output step while the output side
// stalls. The single-port line store read and write of each pixel and the square root,
// which resolves one bit per cycle, set how long an item takes. A result held in the output
// register does not block acceptance of the next item. Set image_width and image_height
// only while the core is idle; out-of-range values are clamped to 1 and the maximum.
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_magnitude_core #(
    parameter int MAX_WIDTH  = sobm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sobm_pkg::MAX_HEIGHT_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [sobm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [sobm_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: luma[7:0], alpha[15:8].
    input  wire  [sobm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // Fields from bit 0: col[10:0], row[21:11], magnitude[29:22], alpha_out[37:30], zeros.
    output logic [sobm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tlast
);

    localparam int PW    = sobm_pkg::PIX_W;
    localparam int POS_W = sobm_pkg::POS_W;
    localparam int PAD_W = sobm_pkg::OUT_TDATA_W - 2 * POS_W - 2 * PW;

    sobm_pkg::t_cmd    cmd;
    sobm_pkg::t_status status;
    logic [POS_W-1:0]  out_col;
    logic [POS_W-1:0]  out_row;
    logic [PW-1:0]     out_mag;
    logic [PW-1:0]     out_alpha;

    sobm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    sobm_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_luma      (s_axis_tdata[PW-1:0]),
        .i_alpha     (s_axis_tdata[2*PW-1:PW]),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_col       (out_col),
        .o_row       (out_row),
        .o_magnitude (out_mag),
        .o_alpha_out (out_alpha),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, out_alpha, out_mag, out_row, out_col};

endmodule

`default_nettype wire
